### sv/mpgd_pkg.sv
package mpgd_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int GLYPH_WORDS_DEF   = 2048;

  localparam int FIRST_CODE = 32;

  localparam logic [2:0] KIND_FILL   = 3'd0;
  localparam logic [2:0] KIND_PIXEL  = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_CHAR   = 3'd3;
  localparam logic [2:0] KIND_LOAD   = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic REG_GLYPH_WIDTH  = 1'b0;
  localparam logic REG_GLYPH_HEIGHT = 1'b1;

  localparam logic [4:0] GLYPH_WIDTH_RST  = 5'd6;
  localparam logic [4:0] GLYPH_HEIGHT_RST = 5'd8;

  typedef struct packed {
    logic        en;
    logic [10:0] addr;
    logic [15:0] bits;
  } gload_t;

endpackage

### sv/mpgd_glyph_store.sv
module mpgd_glyph_store
  import mpgd_pkg::*;
#(
  parameter int GLYPH_WORDS = GLYPH_WORDS_DEF,
  localparam int GA_W = $clog2(GLYPH_WORDS),
  localparam int LA_W = (GA_W > 11) ? GA_W : 11
) (
  input  logic            clk,
  input  gload_t          load,
  input  logic            rd_en,
  input  logic [GA_W-1:0] rd_addr,
  input  logic [4:0]      glyph_height,
  input  logic [2:0]      row_off,
  output logic [23:0]     col_bits
);

  logic [15:0]     mem [GLYPH_WORDS];
  logic [15:0]     rdata;
  logic [15:0]     hmask;
  logic [LA_W-1:0] load_addr;

  assign load_addr = LA_W'(load.addr);

  always_ff @(posedge clk) begin
    if (load.en && (32'(load.addr) < 32'(GLYPH_WORDS))) begin
      mem[load_addr[GA_W-1:0]] <= load.bits;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Rows at or beyond the glyph height, and beyond sixteen, are never lit.
  always_comb begin
    if (glyph_height >= 5'd16) begin
      hmask = 16'hFFFF;
    end else begin
      hmask = 16'((17'd1 << glyph_height) - 17'd1);
    end
  end

  assign col_bits = 24'(rdata & hmask) << row_off;

endmodule

### sv/mono_page_framebuffer_glyph_draw.sv
// Per item: cursor, load and other kinds go straight to the result; an in-range pixel or
// read reads its frame byte, a pixel then writes it; a fill writes every frame byte; a char
// does a check, then per glyph column a glyph store read and, on each of three pages, a
// frame store read and write where the column has lit bits. One item is worked at a time;
// the next may be accepted while the last result waits. Reset (rst, synchronous) clears
// the cursor, restores glyph sizes and zeroes the frame store, taking no item meanwhile.
module mono_page_framebuffer_glyph_draw
  import mpgd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int GLYPH_WORDS   = GLYPH_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[7:0], pos_y[15:8], ink[16], char_code[24:17], glyph_addr[35:25],
  // glyph_bits[51:36], frame_addr[61:52], zero fill above.
  input  logic [63:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], read_byte[9:2], cursor_col[17:10], zero fill above.
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int GA_W = $clog2(GLYPH_WORDS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_PIX_RD = 4'd3;
  localparam logic [3:0] S_PIX_WR = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_GRD    = 4'd6;
  localparam logic [3:0] S_FRD    = 4'd7;
  localparam logic [3:0] S_FWR    = 4'd8;
  localparam logic [3:0] S_RDB    = 4'd9;
  localparam logic [3:0] S_RDW    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [2:0]  in_kind;
  logic [7:0]  in_pos_x;
  logic [7:0]  in_pos_y;
  logic        in_ink;
  logic [7:0]  in_char_code;
  logic [10:0] in_glyph_addr;
  logic [15:0] in_glyph_bits;
  logic [9:0]  in_frame_addr;
  logic        accept;

  assign in_kind       = s_tuser;
  assign in_pos_x      = s_tdata[7:0];
  assign in_pos_y      = s_tdata[15:8];
  assign in_ink        = s_tdata[16];
  assign in_char_code  = s_tdata[24:17];
  assign in_glyph_addr = s_tdata[35:25];
  assign in_glyph_bits = s_tdata[51:36];
  assign in_frame_addr = s_tdata[61:52];

  logic [3:0]      state;
  logic [3:0]      state_next;
  logic [7:0]      px_r;
  logic [7:0]      py_r;
  logic            ink_r;
  logic [7:0]      code_r;
  logic [9:0]      faddr_r;
  logic [7:0]      cursor_x;
  logic [7:0]      cursor_y;
  logic [4:0]      glyph_width;
  logic [4:0]      glyph_height;
  logic [4:0]      col_j;
  logic [1:0]      page_k;
  logic [GA_W-1:0] base_r;
  logic [FA_W-1:0] sweep;
  logic [1:0]      res_status;
  logic [7:0]      res_byte;

  logic [7:0]      fmem [FRAME_BYTES];
  logic            fr_rd_en;
  logic [FA_W-1:0] fr_addr;
  logic [7:0]      fr_rdata;
  logic            fw_en;
  logic [FA_W-1:0] fw_addr;
  logic [7:0]      fw_data;

  gload_t          gload;
  logic            g_rd_en;
  logic [GA_W-1:0] g_rd_addr;
  logic [23:0]     col_bits;
  logic [7:0]      col_byte;

  logic [FA_W-1:0] pix_addr;
  logic [7:0]      pix_bit;
  logic [FA_W-1:0] draw_addr;
  logic [31:0]     base_full;
  logic            no_fit;
  logic            out_of_store;
  logic            sweep_last;
  logic            page_last;
  logic            col_last;
  logic            out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign gload.en   = accept && (in_kind == KIND_LOAD);
  assign gload.addr = in_glyph_addr;
  assign gload.bits = in_glyph_bits;

  assign g_rd_en   = (state == S_GRD);
  assign g_rd_addr = base_r + GA_W'(col_j);

  mpgd_glyph_store #(
    .GLYPH_WORDS(GLYPH_WORDS)
  ) u_glyph (
    .clk         (clk),
    .load        (gload),
    .rd_en       (g_rd_en),
    .rd_addr     (g_rd_addr),
    .glyph_height(glyph_height),
    .row_off     (cursor_y[2:0]),
    .col_bits    (col_bits)
  );

  always_comb begin
    case (page_k)
      2'd0:    col_byte = col_bits[7:0];
      2'd1:    col_byte = col_bits[15:8];
      2'd2:    col_byte = col_bits[23:16];
      default: col_byte = 8'h00;
    endcase
  end

  assign pix_addr  = FA_W'(32'(px_r) + 32'(py_r[7:3]) * SCREEN_WIDTH);
  assign pix_bit   = 8'h01 << py_r[2:0];
  assign draw_addr = FA_W'(32'(cursor_x) + 32'(col_j)
                           + (32'(cursor_y[7:3]) + 32'(page_k)) * SCREEN_WIDTH);

  assign no_fit = (32'(cursor_x) + 32'(glyph_width) > 32'(SCREEN_WIDTH)) ||
                  (32'(cursor_y) + 32'(glyph_height) > 32'(SCREEN_HEIGHT));
  assign base_full = (32'(code_r) - 32'(FIRST_CODE)) * 32'(glyph_width);
  assign out_of_store = (32'(code_r) < 32'(FIRST_CODE)) ||
                        ((glyph_width != 5'd0) &&
                         (base_full + 32'(glyph_width) - 32'd1 >= 32'(GLYPH_WORDS)));

  assign sweep_last = (32'(sweep) == 32'(FRAME_BYTES - 1));
  assign page_last  = (page_k == 2'd2);
  assign col_last   = (col_j == glyph_width - 5'd1);

  always_comb begin
    fr_rd_en = 1'b0;
    fr_addr  = pix_addr;
    fw_en    = 1'b0;
    fw_addr  = sweep;
    fw_data  = 8'h00;
    case (state)
      S_CLEAR: begin
        fw_en = 1'b1;
      end
      S_FILL: begin
        fw_en   = 1'b1;
        fw_data = ink_r ? 8'hFF : 8'h00;
      end
      S_PIX_RD: begin
        fr_rd_en = 1'b1;
      end
      S_PIX_WR: begin
        fw_en   = 1'b1;
        fw_addr = pix_addr;
        fw_data = ink_r ? (fr_rdata | pix_bit) : (fr_rdata & ~pix_bit);
      end
      S_FRD: begin
        fr_rd_en = (col_byte != 8'h00);
        fr_addr  = draw_addr;
      end
      S_FWR: begin
        fw_en   = 1'b1;
        fw_addr = draw_addr;
        fw_data = ink_r ? (fr_rdata | col_byte) : (fr_rdata & ~col_byte);
      end
      S_RDB: begin
        fr_rd_en = 1'b1;
        fr_addr  = FA_W'(faddr_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      fmem[fw_addr] <= fw_data;
    end
    if (fr_rd_en) begin
      fr_rdata <= fmem[fr_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_FILL: state_next = S_FILL;
            KIND_PIXEL: begin
              if ((32'(in_pos_x) < 32'(SCREEN_WIDTH)) &&
                  (32'(in_pos_y) < 32'(SCREEN_HEIGHT))) begin
                state_next = S_PIX_RD;
              end else begin
                state_next = S_DONE;
              end
            end
            KIND_CHAR: state_next = S_CHK;
            KIND_READ: begin
              if (32'(in_frame_addr) < 32'(FRAME_BYTES)) begin
                state_next = S_RDB;
              end else begin
                state_next = S_DONE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        if (sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_PIX_RD: state_next = S_PIX_WR;
      S_PIX_WR: state_next = S_DONE;
      S_CHK: begin
        if (no_fit || out_of_store || (glyph_width == 5'd0)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_GRD;
        end
      end
      S_GRD: state_next = S_FRD;
      S_FRD: begin
        if (col_byte != 8'h00) begin
          state_next = S_FWR;
        end else if (page_last) begin
          state_next = col_last ? S_DONE : S_GRD;
        end
      end
      S_FWR: begin
        if (page_last) begin
          state_next = col_last ? S_DONE : S_GRD;
        end else begin
          state_next = S_FRD;
        end
      end
      S_RDB: state_next = S_RDW;
      S_RDW: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep        <= '0;
      cursor_x     <= 8'd0;
      cursor_y     <= 8'd0;
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg_index == REG_GLYPH_WIDTH) begin
          glyph_width <= cfg_data;
        end
        if (cfg_index == REG_GLYPH_HEIGHT) begin
          glyph_height <= cfg_data;
        end
      end

      if ((state == S_CLEAR) || (state == S_FILL)) begin
        sweep <= sweep_last ? '0 : sweep + FA_W'(1);
      end

      if (accept) begin
        px_r       <= in_pos_x;
        py_r       <= in_pos_y;
        ink_r      <= in_ink;
        code_r     <= in_char_code;
        faddr_r    <= in_frame_addr;
        res_status <= ST_OK;
        res_byte   <= 8'h00;
        if (in_kind == KIND_CURSOR) begin
          cursor_x <= in_pos_x;
          cursor_y <= in_pos_y;
        end
      end

      if (state == S_CHK) begin
        col_j  <= 5'd0;
        page_k <= 2'd0;
        base_r <= GA_W'(base_full);
        if (no_fit) begin
          res_status <= ST_NO_FIT;
        end else if (out_of_store) begin
          res_status <= ST_RANGE;
        end else if (glyph_width == 5'd0) begin
          cursor_x <= cursor_x + 8'd1;
        end
      end

      if (((state == S_FRD) && (col_byte == 8'h00)) || (state == S_FWR)) begin
        if (page_last) begin
          page_k <= 2'd0;
          col_j  <= col_j + 5'd1;
          if (col_last) begin
            cursor_x <= cursor_x + 8'(glyph_width) + 8'd1;
          end
        end else begin
          page_k <= page_k + 2'd1;
        end
      end

      if (state == S_RDW) begin
        res_byte <= fr_rdata;
      end

      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {6'b0, cursor_x, res_byte, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in work");

  // A new result is only raised from the done state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");

  // Frame writes stay inside the frame store.
  a_fw_range: assert property (@(posedge clk) disable iff (rst)
    fw_en |-> (32'(fw_addr) < 32'(FRAME_BYTES)))
    else $error("frame write beyond the store");

  // Glyph words are only read while drawing a character.
  a_grd_kind: assert property (@(posedge clk) disable iff (rst)
    g_rd_en |-> ((state == S_GRD) && !no_fit && (glyph_width != 5'd0)))
    else $error("glyph read outside a character draw");

  // The cursor row only moves on a cursor item.
  a_cursor_y: assert property (@(posedge clk) disable iff (rst)
    !$stable(cursor_y) |-> ($past(accept) && ($past(in_kind) == KIND_CURSOR)))
    else $error("cursor row changed without a cursor item");

endmodule
